[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the block layout checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock with an active-low reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("assertion failed");

// Assertion on the usual clock and reset names.
`define ASSERT_DEF(lbl, prop) `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

[src/bsrl_pkg.sv]
// ----------------------------------------------------------------------------
// Block sparse row layout package
// Types and constants shared by the layout chain and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package bsrl_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned StartW = 31;
  localparam int unsigned WidthW = 8;
  localparam int unsigned RowsW  = 16;
  localparam int unsigned PosW   = 5;
  localparam int unsigned OutPosW = 3;
  localparam int unsigned NprW   = 11;
  localparam int unsigned ProdW  = RowsW + NprW;
  localparam int unsigned TotW   = 31;
  localparam int unsigned StW    = 2;

  localparam logic [StW-1:0] StOk       = 2'd0;
  localparam logic [StW-1:0] StRepeat   = 2'd1;
  localparam logic [StW-1:0] StOverflow = 2'd2;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [StartW-1:0] start;
    logic [WidthW-1:0] width;
    logic [PosW-1:0]   pos;
  } cell_t;

  typedef struct packed {
    logic ins;
    logic drain;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHK,
    S_DRAIN
  } state_e;

endpackage

`default_nettype wire

[src/bsrl_cell.sv]
// ----------------------------------------------------------------------------
// Layout chain cell
// Holds one block, takes part in sorted insertion and shifts out when drained.
// ----------------------------------------------------------------------------
`default_nettype none

module bsrl_cell import bsrl_pkg::*; (
  input  wire logic       clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire cell_t      new_i,
  input  wire cell_t      left_i,
  input  wire cell_t      right_i,
  input  wire logic       occ_i,
  input  wire logic       occ_left_i,
  input  wire logic       shift_left_i,
  output logic            shift_o,
  output logic            match_o,
  output cell_t           data_o
);

  cell_t data_q, data_d;

  assign shift_o = occ_i && (new_i.start < data_q.start);
  assign match_o = occ_i && (new_i.key == data_q.key);
  assign data_o  = data_q;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.drain) begin
      data_d = right_i;
    end else if (ctrl_i.ins) begin
      if (shift_left_i) begin
        data_d = left_i;
      end else if (shift_o || (!occ_i && occ_left_i)) begin
        data_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

`default_nettype wire

[src/block_sparse_row_layout.sv]
// ----------------------------------------------------------------------------
// Block sparse row layout
// Sorts one factor's column blocks and gives offsets, row and value bases.
// ----------------------------------------------------------------------------
// Each input beat carrying a block is inserted into a chain of MAX_BLOCKS
// cells kept sorted by column start; repeated keys are caught by comparing
// against every held cell. The closing beat passes through S_MUL for the
// row-by-width product and S_CHK for the total checks; then the results
// drain from the chain head at one beat per cycle while the output accepts
// them, one beat for a blockless or null factor. The input is not ready
// from the closing beat until the last result is in the output register.
`default_nettype none

module block_sparse_row_layout import bsrl_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // block_key[63:0], column_start[94:64], column_width[102:95], row_count[118:103]
  input  wire logic [119:0] s_axis_tdata,
  // factor_null[0], has_block[1]
  input  wire logic [1:0]   s_axis_tuser,
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // block_position[2:0], value_offset[13:3], nonzeros_per_row[24:14],
  // row_begin[55:25], nonzero_begin[86:56]
  output logic [87:0]       m_axis_tdata,
  // block_valid[0], status[2:1]
  output logic [2:0]        m_axis_tuser,
  output logic              m_axis_tlast
);

  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);

  state_e state_q, state_d;

  logic [CntW-1:0]   count_q, count_d;
  logic [NprW-1:0]   npr_q, npr_d;
  logic              rep_q, rep_d;
  logic              ovf_q, ovf_d;
  logic              null_q, null_d;
  logic              single_q, single_d;
  logic [RowsW-1:0]  rows_q, rows_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [TotW-1:0]   trow_q, trow_d, tnz_q, tnz_d;
  logic [TotW-1:0]   brow_q, brow_d, bnz_q, bnz_d;
  logic [StW-1:0]    st_q, st_d;
  logic [NprW-1:0]   acc_q, acc_d;
  logic              ovld_q, ovld_d;
  logic [87:0]       odata_q, odata_d;
  logic [2:0]        ouser_q, ouser_d;
  logic              olast_q, olast_d;

  logic              in_fire, ready, emit, drain;
  logic              rep_hit, do_ins, blk_ovf;
  logic [31:0]       lastcol, sum_rows, sum_nz;
  cell_t             new_cell;
  cell_ctrl_t        ctrl;

  cell_t             cdata [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] shift, match, occ;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign emit    = !ovld_q || m_axis_tready;

  assign new_cell.key   = s_axis_tdata[63:0];
  assign new_cell.start = s_axis_tdata[94:64];
  assign new_cell.width = s_axis_tdata[102:95];
  assign new_cell.pos   = PosW'(count_q);

  assign rep_hit = |match;
  assign do_ins  = in_fire && s_axis_tuser[1] && !s_axis_tuser[0] && !rep_hit &&
                   (count_q < CntW'(MAX_BLOCKS));
  assign lastcol = {1'b0, new_cell.start} + {24'd0, new_cell.width};
  assign blk_ovf = (new_cell.width != '0) && (lastcol > 32'h8000_0000);

  assign ctrl.ins   = do_ins;
  assign ctrl.drain = drain;

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    assign occ[i] = count_q > CntW'(i);
    bsrl_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_i        (new_cell),
      .left_i       ((i == 0) ? new_cell : cdata[(i == 0) ? 0 : i - 1]),
      .right_i      ((i == MAX_BLOCKS - 1) ? cdata[i] :
                     cdata[(i == MAX_BLOCKS - 1) ? i : i + 1]),
      .occ_i        (occ[i]),
      .occ_left_i   ((i == 0) ? 1'b1 : occ[(i == 0) ? 0 : i - 1]),
      .shift_left_i ((i == 0) ? 1'b0 : shift[(i == 0) ? 0 : i - 1]),
      .shift_o      (shift[i]),
      .match_o      (match[i]),
      .data_o       (cdata[i])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && s_axis_tlast) begin
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_CHK;
      S_CHK: state_d = S_DRAIN;
      S_DRAIN: begin
        if (emit && (single_q || count_q == CntW'(1))) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ready = 1'b0;
    drain = 1'b0;
    unique case (state_q)
      S_IDLE:  ready = 1'b1;
      S_DRAIN: drain = emit && !single_q;
      default: ;
    endcase
  end

  assign s_axis_tready = ready;

  assign sum_rows = {1'b0, trow_q} + {16'd0, rows_q};
  assign sum_nz   = {1'b0, tnz_q} + {5'd0, prod_q};

  always_comb begin
    count_d  = count_q;
    npr_d    = npr_q;
    rep_d    = rep_q;
    ovf_d    = ovf_q;
    null_d   = null_q;
    single_d = single_q;
    rows_d   = rows_q;
    prod_d   = prod_q;
    trow_d   = trow_q;
    tnz_d    = tnz_q;
    brow_d   = brow_q;
    bnz_d    = bnz_q;
    st_d     = st_q;
    acc_d    = acc_q;
    ovld_d   = ovld_q;
    odata_d  = odata_q;
    ouser_d  = ouser_q;
    olast_d  = olast_q;
    if (ovld_q && m_axis_tready) begin
      ovld_d = 1'b0;
    end
    if (in_fire) begin
      if (do_ins) begin
        count_d = count_q + CntW'(1);
        npr_d   = npr_q + NprW'(new_cell.width);
        ovf_d   = ovf_q || blk_ovf;
      end
      if (s_axis_tuser[1] && !s_axis_tuser[0] && rep_hit) begin
        rep_d = 1'b1;
      end
      rows_d = s_axis_tdata[118:103];
      null_d = s_axis_tuser[0];
    end
    if (state_q == S_MUL) begin
      prod_d = ProdW'(rows_q * npr_q);
    end
    if (state_q == S_CHK) begin
      brow_d   = trow_q;
      bnz_d    = tnz_q;
      single_d = null_q || (count_q == '0);
      acc_d    = '0;
      if (null_q) begin
        st_d    = StOk;
        count_d = '0;
        npr_d   = '0;
      end else if (rep_q) begin
        st_d = StRepeat;
      end else if (ovf_q || sum_rows[31] || sum_nz[31]) begin
        st_d = StOverflow;
      end else begin
        st_d   = StOk;
        trow_d = sum_rows[TotW-1:0];
        tnz_d  = sum_nz[TotW-1:0];
      end
    end
    if (state_q == S_DRAIN && emit) begin
      ovld_d = 1'b1;
      if (single_q) begin
        odata_d = {1'b0, bnz_q, brow_q, NprW'(0), NprW'(0), OutPosW'(0)};
        ouser_d = {st_q, 1'b0};
        olast_d = 1'b1;
      end else begin
        odata_d = {1'b0, bnz_q, brow_q, npr_q, acc_q, cdata[0].pos[OutPosW-1:0]};
        ouser_d = {st_q, 1'b1};
        olast_d = (count_q == CntW'(1));
        acc_d   = acc_q + NprW'(cdata[0].width);
        count_d = count_q - CntW'(1);
      end
      if (single_q || count_q == CntW'(1)) begin
        count_d = '0;
        npr_d   = '0;
        rep_d   = 1'b0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      npr_q    <= '0;
      rep_q    <= 1'b0;
      ovf_q    <= 1'b0;
      null_q   <= 1'b0;
      single_q <= 1'b0;
      trow_q   <= '0;
      tnz_q    <= '0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      npr_q    <= npr_d;
      rep_q    <= rep_d;
      ovf_q    <= ovf_d;
      null_q   <= null_d;
      single_q <= single_d;
      trow_q   <= trow_d;
      tnz_q    <= tnz_d;
      ovld_q   <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rows_q  <= rows_d;
    prod_q  <= prod_d;
    brow_q  <= brow_d;
    bnz_q   <= bnz_d;
    st_q    <= st_d;
    acc_q   <= acc_d;
    odata_q <= odata_d;
    ouser_q <= ouser_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;
  assign m_axis_tlast  = olast_q;

endmodule

`default_nettype wire

[src/bsrl_checker.sv]
// ----------------------------------------------------------------------------
// Block sparse row layout checker
// Port-level assertions on the layout block, attached by a bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bsrl_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         s_axis_tlast,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [87:0]  m_axis_tdata,
  input wire logic [2:0]   m_axis_tuser,
  input wire logic         m_axis_tlast
);

  // A closing beat stops further input until the factor has drained.
  `ASSERT_DEF(a_close_blocks, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)

  // A result without a block is always the only and final one.
  `ASSERT_DEF(a_empty_last, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)

  `ASSERT_DEF(a_empty_zero, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[24:0] == 25'd0)

  `ASSERT_DEF(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

endmodule

bind block_sparse_row_layout bsrl_checker u_bsrl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Block sparse row layout testbench
// Drives random and directed factor descriptors into the layout block and
// checks every result beat against a predicted layout, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bsrl_pkg::*;

  localparam int unsigned MaxBlk = 8;
  localparam int unsigned IdleLimit = 20000;
  localparam longint unsigned Lim31 = 64'd2147483647;

  typedef struct packed {
    logic [63:0] key;
    logic [30:0] start;
    logic [7:0]  width;
    logic [15:0] rows;
    logic        is_null;
    logic        has;
    logic        last;
  } desc_t;

  typedef struct packed {
    logic [2:0]  pos;
    logic        bvalid;
    logic [10:0] offs;
    logic [10:0] npr;
    logic [30:0] row_base;
    logic [30:0] nz_base;
    logic [1:0]  st;
    logic        last;
  } layout_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic m_axis_tlast;

  always #4 clk_i = ~clk_i;

  block_sparse_row_layout #(.MAX_BLOCKS(MaxBlk)) i_dut (.*);

  desc_t   pending_descs[$];
  layout_t expected_layouts[$];
  int      errors = 0;
  int      beats_in = 0;
  int      beats_out = 0;
  int      factors_closed = 0;
  bit      hold_send = 1'b0;

  logic [63:0] kept_keys[MaxBlk];
  logic [30:0] kept_starts[MaxBlk];
  logic [7:0]  kept_widths[MaxBlk];
  int          kept_count = 0;
  bit          dup_seen = 1'b0;
  longint unsigned row_sum = 0;
  longint unsigned nz_sum = 0;

  task automatic queue_desc(input desc_t d);
    pending_descs.insert(pending_descs.size(), d);
  endtask

  task automatic queue_layout(input layout_t r);
    expected_layouts.insert(expected_layouts.size(), r);
  endtask

  // Predicted layout for one accepted input beat.
  task automatic predict_layout(input desc_t d);
    layout_t r;
    layout_t sorted[MaxBlk];
    bit dup;
    int rank;
    longint unsigned npr, offs, nrow, nnz;
    logic [1:0] st;
    dup = 1'b0;
    npr = 0;
    st = StOk;
    if (d.has && !d.is_null) begin
      for (int i = 0; i < kept_count; i++) if (kept_keys[i] == d.key) dup = 1'b1;
      if (dup) dup_seen = 1'b1;
      else if (kept_count < MaxBlk) begin
        kept_keys[kept_count] = d.key;
        kept_starts[kept_count] = d.start;
        kept_widths[kept_count] = d.width;
        kept_count++;
      end
    end
    if (!d.last) return;
    factors_closed++;
    r = '0;
    r.row_base = row_sum[30:0];
    r.nz_base = nz_sum[30:0];
    r.last = 1'b1;
    if (d.is_null) begin
      queue_layout(r);
    end else begin
      for (int i = 0; i < kept_count; i++) npr += kept_widths[i];
      if (dup_seen) st = StRepeat;
      else begin
        for (int i = 0; i < kept_count; i++)
          if (kept_widths[i] != 0 &&
              longint'(kept_starts[i]) + kept_widths[i] - 1 > Lim31) st = StOverflow;
        nrow = row_sum + d.rows;
        nnz = nz_sum + longint'(d.rows) * npr;
        if (nrow > Lim31 || nnz > Lim31) st = StOverflow;
      end
      r.st = st;
      if (kept_count == 0) queue_layout(r);
      else begin
        for (int i = 0; i < kept_count; i++) begin
          rank = 0;
          offs = 0;
          for (int j = 0; j < kept_count; j++)
            if (kept_starts[j] < kept_starts[i] ||
                (kept_starts[j] == kept_starts[i] && j < i)) begin
              rank++;
              offs += kept_widths[j];
            end
          sorted[rank] = r;
          sorted[rank].pos = i[2:0];
          sorted[rank].bvalid = 1'b1;
          sorted[rank].offs = offs[10:0];
          sorted[rank].npr = npr[10:0];
          sorted[rank].last = (rank + 1 == kept_count);
        end
        for (int i = 0; i < kept_count; i++) queue_layout(sorted[i]);
      end
      if (st == StOk) begin
        nz_sum += longint'(d.rows) * npr;
        row_sum += d.rows;
      end
    end
    kept_count = 0;
    dup_seen = 1'b0;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver
  int  send_gap = 0;
  desc_t cur;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_layout(cur);
        beats_in++;
        send_gap = gap_len();
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_gap > 0 || hold_send || pending_descs.size() == 0) begin
          if (send_gap > 0) send_gap--;
          s_axis_tvalid <= 1'b0;
        end else begin
          cur = pending_descs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {1'b0, cur.rows, cur.width, cur.start, cur.key};
          s_axis_tuser <= {cur.has, cur.is_null};
          s_axis_tlast <= cur.last;
        end
      end
    end
  end

  // Monitor
  int recv_gap = 0;
  layout_t got, want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats_out++;
        got.pos = m_axis_tdata[2:0];
        got.offs = m_axis_tdata[13:3];
        got.npr = m_axis_tdata[24:14];
        got.row_base = m_axis_tdata[55:25];
        got.nz_base = m_axis_tdata[86:56];
        got.bvalid = m_axis_tuser[0];
        got.st = m_axis_tuser[2:1];
        got.last = m_axis_tlast;
        if (expected_layouts.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errors++;
        end else begin
          want = expected_layouts.pop_front();
          if (got != want) begin
            $display("%0t: mismatch expected %p", $time, want);
            $display("%0t:          actual   %p", $time, got);
            errors++;
          end
        end
        recv_gap = gap_len();
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else m_axis_tready <= 1'b1;
    end
  end

  // Watchdog
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d idle cycles", IdleLimit);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic desc_t blk(input logic [63:0] k, input logic [30:0] s,
                                input logic [7:0] w, input logic [15:0] r,
                                input bit l);
    desc_t d;
    d.key = k;
    d.start = s;
    d.width = w;
    d.rows = r;
    d.is_null = 1'b0;
    d.has = 1'b1;
    d.last = l;
    return d;
  endfunction

  // One well-formed factor with random content; keys drawn from a small pool
  // now and then so that repeats occur.
  task automatic add_factor();
    int n;
    desc_t d;
    logic [63:0] k;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(0, 5) == 0) ? 64'($urandom_range(0, 3))
                                      : {$urandom, $urandom};
      d = blk(k, ($urandom_range(0, 19) == 0) ? 31'($urandom) :
                 31'($urandom_range(0, 4) * 16),
              ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12)),
              ($urandom_range(0, 14) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
              i == n - 1);
      if ($urandom_range(0, 14) == 0) d.has = 1'b0;
      if ($urandom_range(0, 19) == 0) d.is_null = 1'b1;
      queue_desc(d);
    end
  endtask

  initial begin
    desc_t d;
    int target;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, ties, repeat, blockless, null, full store, overflows.
    queue_desc(blk(64'hFFFF_FFFF_FFFF_FFFF, 31'd20, 8'd255, 16'hFFFF, 1'b0));
    queue_desc(blk(64'd0, 31'd20, 8'd3, 16'd0, 1'b0));
    queue_desc(blk(64'd1, 31'd0, 8'd0, 16'd2, 1'b1));
    queue_desc(blk(64'd5, 31'd1, 8'd4, 16'd3, 1'b0));
    queue_desc(blk(64'd5, 31'd2, 8'd4, 16'd3, 1'b1));
    d = blk(64'd9, 31'd0, 8'd0, 16'd7, 1'b1);
    d.has = 1'b0;
    queue_desc(d);
    d = blk(64'd9, 31'd4, 8'd2, 16'd5, 1'b0);
    queue_desc(d);
    d.is_null = 1'b1;
    d.last = 1'b1;
    queue_desc(d);
    for (int i = 0; i < 9; i++)
      queue_desc(blk(64'(100 + i), 31'(90 - i * 10), 8'(i + 1), 16'd1, i == 8));
    queue_desc(blk(64'd7, 31'h7FFF_FFFF, 8'd2, 16'd1, 1'b1));
    queue_desc(blk(64'd7, 31'h7FFF_FFFF, 8'd0, 16'd1, 1'b1));
    queue_desc(blk(64'd8, 31'h7FFF_FFFE, 8'd1, 16'hFFFF, 1'b1));
    for (int i = 0; i < 3; i++)
      queue_desc(blk({$urandom, $urandom}, 31'd0, 8'd255, 16'hFFFF, 1'b1));

    // Random phase; halfway the sender waits for every result to drain.
    while (pending_descs.size() + beats_in < 160) add_factor();
    target = beats_in + pending_descs.size();
    wait (beats_in == target);
    hold_send = 1'b1;
    wait (expected_layouts.size() == 0);
    repeat (5) @(posedge clk_i);
    hold_send = 1'b0;
    while (pending_descs.size() + beats_in < 310) add_factor();
    target = beats_in + pending_descs.size();
    wait (beats_in == target);
    wait (expected_layouts.size() == 0);
    repeat (50) @(posedge clk_i);
    if (expected_layouts.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, expected_layouts.size());
      errors++;
    end
    $display("Sent %0d descriptor beats closing %0d factors; checked %0d result beats.",
             beats_in, factors_closed, beats_out);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/bsrl_pkg.sv
src/bsrl_cell.sv
src/block_sparse_row_layout.sv
src/bsrl_checker.sv
tb/tb_top.sv
